// ===== hdl/ste_pkg.sv =====
package ste_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;

    localparam int OP_W    = 3;
    localparam int MAC_W   = 48;
    localparam int IP_W    = 32;
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 16;
    localparam int SLOT_W  = 8;
    localparam int STAT_W  = 3;

    localparam logic [HOLD_W-1:0] HOLD_OFF_RESET = HOLD_W'(30);

    // Operation codes; the two codes above clear-auth are rejected.
    localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd1;
    localparam logic [OP_W-1:0] OP_AUTHORIZE  = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP_IP  = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP_MAC = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR_AUTH = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_KEPT      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_REJECT    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [MAC_W-1:0]  station_mac;
        logic [IP_W-1:0]   station_ip;
        logic [TIME_W-1:0] now_seconds;
        logic              is_wireless;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_index;
        logic [MAC_W-1:0]  found_mac;
        logic [IP_W-1:0]   found_ip;
        logic              found_auth;
        logic              found_wireless;
    } t_out_item;

    typedef struct packed {
        logic              valid;
        logic              auth;
        logic              wireless;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
        logic [TIME_W-1:0] rtime;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_DONE
    } t_state;

endpackage

// ===== hdl/ste_engine.sv =====
module ste_engine import ste_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_go,
    input  t_in_item          i_item,
    input  logic [HOLD_W-1:0] i_hold,
    input  logic              i_res_take,
    output logic              o_ready,
    output logic              o_res_valid,
    output t_out_item         o_res
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rdata;

    t_state    r_state,   n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_issue, n_issue;
    logic          r_rd_ok, n_rd_ok;
    logic [AW-1:0] r_daddr, n_daddr;
    logic          r_found, n_found;
    logic          r_free_ok, n_free_ok;
    logic [AW-1:0] r_free, n_free;
    logic [AW-1:0] r_hit, n_hit;
    t_entry        r_hit_ent, n_hit_ent;
    t_in_item      r_item, n_item;
    t_out_item     r_res, n_res;

    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          hit_now;
    logic [TIME_W-1:0] age;

    function automatic logic is_reject(input t_in_item it);
        logic bad_mac;
        logic bad_ip;
        bad_mac = (it.station_mac == '0);
        bad_ip  = (it.station_ip == '0);
        case (it.operation)
            OP_ADD, OP_DELETE, OP_AUTHORIZE: is_reject = bad_mac || bad_ip;
            OP_LOOKUP_IP:                    is_reject = bad_ip;
            OP_LOOKUP_MAC:                   is_reject = bad_mac;
            OP_CLEAR_AUTH:                   is_reject = 1'b0;
            default:                         is_reject = 1'b1;
        endcase
    endfunction

    // Memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    // The shared compare unit: one stored entry against the key per cycle.
    always_comb begin
        case (r_item.operation)
            OP_LOOKUP_IP:  hit_now = r_rdata.valid && (r_rdata.ip == r_item.station_ip);
            OP_LOOKUP_MAC: hit_now = r_rdata.valid && (r_rdata.mac == r_item.station_mac);
            OP_CLEAR_AUTH: hit_now = 1'b0;
            default:       hit_now = r_rdata.valid && (r_rdata.mac == r_item.station_mac)
                                     && (r_rdata.ip == r_item.station_ip);
        endcase
    end

    assign age = r_item.now_seconds - r_hit_ent.rtime;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_issue   = r_issue;
        n_rd_ok   = 1'b0;
        n_daddr   = r_addr;
        n_found   = r_found;
        n_free_ok = r_free_ok;
        n_free    = r_free;
        n_hit     = r_hit;
        n_hit_ent = r_hit_ent;
        n_item    = r_item;
        n_res     = r_res;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_addr;
        wr_data   = '0;

        case (r_state)
            S_CLEAR: begin
                wr_en  = 1'b1;
                n_addr = r_addr + AW'(1);
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_item_go) begin
                    n_item    = i_item;
                    n_found   = 1'b0;
                    n_free_ok = 1'b0;
                    n_free    = '0;
                    n_addr    = '0;
                    n_issue   = 1'b1;
                    n_res     = '0;
                    if (is_reject(i_item)) begin
                        n_res.status = STAT_REJECT;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                rd_en   = r_issue;
                n_rd_ok = r_issue;
                if (r_issue) begin
                    if (r_addr == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (r_rd_ok) begin
                    if (r_item.operation == OP_CLEAR_AUTH && r_rdata.valid) begin
                        wr_en         = 1'b1;
                        wr_addr       = r_daddr;
                        wr_data       = r_rdata;
                        wr_data.auth  = 1'b0;
                    end
                    if (!r_rdata.valid && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_daddr;
                    end
                    if (hit_now) begin
                        n_found   = 1'b1;
                        n_hit     = r_daddr;
                        n_hit_ent = r_rdata;
                        n_issue   = 1'b0;
                        n_rd_ok   = 1'b0;
                        n_state   = S_FINISH;
                    end else if (r_daddr == LAST) begin
                        n_state = S_FINISH;
                    end
                end
            end

            S_FINISH: begin
                n_state = S_DONE;
                n_res   = '0;
                wr_addr = r_hit;
                case (r_item.operation)
                    OP_ADD: begin
                        if (r_found) begin
                            wr_en            = 1'b1;
                            wr_data          = r_hit_ent;
                            wr_data.rtime    = r_item.now_seconds;
                            n_res.slot_index = SLOT_W'(r_hit);
                        end else if (r_free_ok) begin
                            wr_en            = 1'b1;
                            wr_addr          = r_free;
                            wr_data.valid    = 1'b1;
                            wr_data.wireless = r_item.is_wireless;
                            wr_data.mac      = r_item.station_mac;
                            wr_data.ip       = r_item.station_ip;
                            wr_data.rtime    = r_item.now_seconds;
                            n_res.slot_index = SLOT_W'(r_free);
                        end else begin
                            n_res.status = STAT_FULL;
                        end
                    end
                    OP_DELETE: begin
                        if (!r_found) begin
                            n_res.status = STAT_NOT_FOUND;
                        end else begin
                            n_res.slot_index = SLOT_W'(r_hit);
                            if (age < TIME_W'(i_hold)) begin
                                n_res.status = STAT_KEPT;
                            end else begin
                                wr_en = 1'b1;
                            end
                        end
                    end
                    OP_AUTHORIZE: begin
                        if (!r_found) begin
                            n_res.status = STAT_NOT_FOUND;
                        end else begin
                            wr_en            = 1'b1;
                            wr_data          = r_hit_ent;
                            wr_data.auth     = 1'b1;
                            n_res.slot_index = SLOT_W'(r_hit);
                        end
                    end
                    OP_LOOKUP_IP, OP_LOOKUP_MAC: begin
                        if (!r_found) begin
                            n_res.status = STAT_NOT_FOUND;
                        end else begin
                            n_res.slot_index     = SLOT_W'(r_hit);
                            n_res.found_auth     = r_hit_ent.auth;
                            n_res.found_wireless = r_hit_ent.wireless;
                            if (r_item.operation == OP_LOOKUP_IP) begin
                                n_res.found_mac = r_hit_ent.mac;
                            end else begin
                                n_res.found_ip = r_hit_ent.ip;
                            end
                        end
                    end
                    default: begin
                        n_res.status = STAT_OK;
                    end
                endcase
            end

            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_issue   <= 1'b0;
            r_rd_ok   <= 1'b0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_issue   <= n_issue;
            r_rd_ok   <= n_rd_ok;
            r_found   <= n_found;
            r_free_ok <= n_free_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_daddr   <= n_daddr;
        r_free    <= n_free;
        r_hit     <= n_hit;
        r_hit_ent <= n_hit_ent;
        r_item    <= n_item;
        r_res     <= n_res;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// ===== hdl/station_table_engine_top.sv =====
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_stall o_out_data (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (hold-off seconds)
//
// Each operation finishes before the next input transaction is accepted: the table
// sits in one memory with a single read port, and one compare unit checks one entry per
// cycle. Searches stop at the first match; adds of a new station, clear-auth and misses
// scan the whole table.
// Rejected keys go straight to the result without a table scan.
// After reset the memory is zeroed one entry per cycle while the input channel stalls;
// configuration writes are taken throughout.
// A result waits in the output register while the next transaction is accepted.
module station_table_engine_top import ste_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [HOLD_W-1:0] i_cfg_data
);

    logic [HOLD_W-1:0] r_hold;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic      eng_ready;
    logic      res_valid;
    t_out_item res;
    logic      res_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !eng_ready;
    assign res_take    = res_valid && (!r_out_valid || !i_out_stall);

    ste_engine #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item_go  (i_in_valid && eng_ready),
        .i_item     (i_in_data),
        .i_hold     (r_hold),
        .i_res_take (res_take),
        .o_ready    (eng_ready),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= HOLD_OFF_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_hold <= i_cfg_data;
            end
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ste_pkg::*;

    localparam int TABLE_SIZE  = TABLE_ENTRIES_DEF;
    localparam int KEY_POOL    = 16;
    localparam int MIXED_ITEMS = 130;

    // The block rejects the two codes above clear-auth.
    localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;
    localparam logic [OP_W-1:0] KEYED_OPS [5] = '{OP_ADD, OP_DELETE, OP_AUTHORIZE,
                                                  OP_LOOKUP_IP, OP_LOOKUP_MAC};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [HOLD_W-1:0] i_cfg_data = '0;

    // Mirror of the station table and of the hold-off register.
    t_entry            station_tbl [TABLE_SIZE];
    logic [HOLD_W-1:0] hold_off_setting = HOLD_OFF_RESET;
    t_out_item         pending_replies [$];
    logic [TIME_W-1:0] clock_now = '0;
    int                mismatch_count = 0;
    int                quiet_items = 0;

    station_table_engine_top #(
        .TABLE_ENTRIES(TABLE_SIZE)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        foreach (station_tbl[s]) station_tbl[s] = '0;
    end

    function automatic t_out_item apply_station_op(t_in_item item);
        t_out_item         reply;
        int                hit;
        logic [TIME_W-1:0] age;
        reply = '0;
        reply.status = STAT_OK;
        hit = -1;
        case (item.operation)
            OP_ADD, OP_DELETE, OP_AUTHORIZE: begin
                if (item.station_mac == '0 || item.station_ip == '0) begin
                    reply.status = STAT_REJECT;
                end else begin
                    for (int s = 0; s < TABLE_SIZE && hit < 0; s++) begin
                        if (station_tbl[s].valid && station_tbl[s].mac == item.station_mac
                            && station_tbl[s].ip == item.station_ip) begin
                            hit = s;
                        end
                    end
                    if (item.operation == OP_ADD) begin
                        // Without a match the station goes into the lowest free slot.
                        for (int s = 0; s < TABLE_SIZE && hit < 0; s++) begin
                            if (!station_tbl[s].valid) begin
                                hit = s;
                                station_tbl[s].valid    = 1'b1;
                                station_tbl[s].auth     = 1'b0;
                                station_tbl[s].wireless = item.is_wireless;
                                station_tbl[s].mac      = item.station_mac;
                                station_tbl[s].ip       = item.station_ip;
                            end
                        end
                        if (hit < 0) begin
                            reply.status = STAT_FULL;
                        end else begin
                            station_tbl[hit].rtime = item.now_seconds;
                            reply.slot_index = SLOT_W'(hit);
                        end
                    end else if (hit < 0) begin
                        reply.status = STAT_NOT_FOUND;
                    end else begin
                        reply.slot_index = SLOT_W'(hit);
                        if (item.operation == OP_AUTHORIZE) begin
                            station_tbl[hit].auth = 1'b1;
                        end else begin
                            age = item.now_seconds - station_tbl[hit].rtime;
                            if (age < TIME_W'(hold_off_setting)) begin
                                reply.status = STAT_KEPT;
                            end else begin
                                station_tbl[hit] = '0;
                            end
                        end
                    end
                end
            end
            OP_LOOKUP_IP, OP_LOOKUP_MAC: begin
                if ((item.operation == OP_LOOKUP_IP) ? item.station_ip == '0
                                                     : item.station_mac == '0) begin
                    reply.status = STAT_REJECT;
                end else begin
                    reply.status = STAT_NOT_FOUND;
                    for (int s = 0; s < TABLE_SIZE && hit < 0; s++) begin
                        if (station_tbl[s].valid &&
                            ((item.operation == OP_LOOKUP_IP) ?
                             station_tbl[s].ip == item.station_ip :
                             station_tbl[s].mac == item.station_mac)) begin
                            hit = s;
                        end
                    end
                    if (hit >= 0) begin
                        reply.status = STAT_OK;
                        reply.slot_index = SLOT_W'(hit);
                        if (item.operation == OP_LOOKUP_IP) begin
                            reply.found_mac = station_tbl[hit].mac;
                        end else begin
                            reply.found_ip = station_tbl[hit].ip;
                        end
                        reply.found_auth     = station_tbl[hit].auth;
                        reply.found_wireless = station_tbl[hit].wireless;
                    end
                end
            end
            OP_CLEAR_AUTH: begin
                foreach (station_tbl[s]) begin
                    if (station_tbl[s].valid) station_tbl[s].auth = 1'b0;
                end
            end
            default: begin
                reply.status = STAT_REJECT;
            end
        endcase
        return reply;
    endfunction

    function automatic t_in_item op_item(logic [OP_W-1:0] op, logic [MAC_W-1:0] mac,
                                         logic [IP_W-1:0] ip, logic [TIME_W-1:0] now,
                                         logic wireless);
        t_in_item item;
        item.operation   = op;
        item.station_mac = mac;
        item.station_ip  = ip;
        item.now_seconds = now;
        item.is_wireless = wireless;
        return item;
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [MAC_W-1:0] mac;
        do begin
            mac = {16'($urandom), $urandom};
        end while (mac == '0);
        return mac;
    endfunction

    function automatic logic [IP_W-1:0] random_ip();
        logic [IP_W-1:0] ip;
        do begin
            ip = $urandom;
        end while (ip == '0);
        return ip;
    endfunction

    // Mostly short pauses, now and then one that outlasts a whole table scan.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 4);
        if (roll < 97) return $urandom_range(5, 30);
        return $urandom_range(100, 300);
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_op(input t_in_item item, output t_out_item reply);
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = item;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        reply = apply_station_op(item);
        pending_replies.push_back(reply);
        if (quiet_items > 0) begin
            quiet_items--;
            gap = 0;
        end else begin
            gap = idle_length();
            if ($urandom_range(0, 39) == 0) quiet_items = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic settle_queue();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_hold_off(input logic [HOLD_W-1:0] value);
        settle_queue();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do begin
            @(posedge i_clk);
        end while (o_cfg_ready !== 1'b1);
        hold_off_setting = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Every rejection, each operation but delete on a hit and a miss, and the age
    // check across the wrap of the seconds counter, at the reset hold-off.
    task automatic test_directed_ops();
        t_out_item         reply;
        logic [MAC_W-1:0]  mac_a, mac_b;
        logic [IP_W-1:0]   ip_a, ip_b;
        mac_a = '1;
        ip_a  = '1;
        mac_b = MAC_W'(1);
        ip_b  = IP_W'(1);
        send_op(op_item(OP_ADD, '0, ip_a, '0, 1'b1), reply);
        send_op(op_item(OP_DELETE, mac_a, '0, '1, 1'b0), reply);
        send_op(op_item(OP_AUTHORIZE, '0, '0, '0, 1'b0), reply);
        send_op(op_item(OP_LOOKUP_IP, mac_a, '0, '0, 1'b0), reply);
        send_op(op_item(OP_LOOKUP_MAC, '0, ip_a, '0, 1'b1), reply);
        send_op(op_item(OP_RESERVED_LO, mac_a, ip_a, '1, 1'b1), reply);
        send_op(op_item(OP_RESERVED_HI, mac_b, ip_b, '0, 1'b0), reply);
        send_op(op_item(OP_ADD, mac_a, ip_a, 32'hFFFF_FFF0, 1'b1), reply);
        send_op(op_item(OP_ADD, mac_b, ip_b, '0, 1'b0), reply);
        send_op(op_item(OP_ADD, mac_a, ip_a, 32'hFFFF_FFF8, 1'b0), reply);
        send_op(op_item(OP_LOOKUP_IP, '0, ip_a, '0, 1'b0), reply);
        send_op(op_item(OP_LOOKUP_MAC, mac_b, '0, '0, 1'b0), reply);
        send_op(op_item(OP_AUTHORIZE, mac_a, ip_a, '0, 1'b0), reply);
        send_op(op_item(OP_LOOKUP_MAC, mac_a, ip_b, '0, 1'b0), reply);
        send_op(op_item(OP_AUTHORIZE, mac_a, ip_b, '0, 1'b0), reply);
        // Refreshed 13 seconds ago across the wrap, so the delete is held off.
        send_op(op_item(OP_DELETE, mac_a, ip_a, 32'd5, 1'b0), reply);
        send_op(op_item(OP_CLEAR_AUTH, mac_a, ip_a, '0, 1'b1), reply);
        send_op(op_item(OP_LOOKUP_IP, '0, ip_a, '0, 1'b0), reply);
        send_op(op_item(OP_DELETE, mac_a, ip_a, 32'd22, 1'b0), reply);
        send_op(op_item(OP_LOOKUP_MAC, mac_a, '0, '0, 1'b0), reply);
        send_op(op_item(OP_LOOKUP_IP, '0, ip_a, '0, 1'b0), reply);
        send_op(op_item(OP_DELETE, mac_b, ip_b, 32'd29, 1'b0), reply);
        send_op(op_item(OP_ADD, mac_a, ip_a, 32'd40, 1'b1), reply);
        send_op(op_item(OP_LOOKUP_IP, '0, random_ip(), '0, 1'b0), reply);
    endtask

    task automatic test_hold_off_limits();
        t_out_item        reply;
        logic [MAC_W-1:0] mac_c;
        logic [IP_W-1:0]  ip_c;
        mac_c = random_mac();
        ip_c  = random_ip();
        write_hold_off('0);
        send_op(op_item(OP_ADD, mac_c, ip_c, 32'd100, 1'b1), reply);
        send_op(op_item(OP_DELETE, mac_c, ip_c, 32'd100, 1'b0), reply);
        write_hold_off('1);
        send_op(op_item(OP_ADD, mac_c, ip_c, 32'hFFFF_0001, 1'b0), reply);
        send_op(op_item(OP_DELETE, mac_c, ip_c, 32'hFFFF_FFFF, 1'b0), reply);
        send_op(op_item(OP_DELETE, mac_c, ip_c, 32'h0000_0000, 1'b0), reply);
    endtask

    // A small pool of keys, some sharing a MAC and some an IP, keeps hits frequent.
    task automatic test_mixed_traffic();
        logic [MAC_W-1:0]  pool_mac [KEY_POOL];
        logic [IP_W-1:0]   pool_ip  [KEY_POOL];
        logic [HOLD_W-1:0] settings [4];
        t_in_item          item;
        t_out_item         reply;
        int                pick, a, b, zero_sel;
        settings[0] = HOLD_OFF_RESET;
        settings[1] = HOLD_W'($urandom_range(1, 200));
        settings[2] = '1;
        settings[3] = HOLD_W'($urandom);
        foreach (settings[p]) begin
            write_hold_off(settings[p]);
            clock_now = $urandom;
            for (int k = 0; k < KEY_POOL; k++) begin
                pool_mac[k] = (k % 4 == 1) ? pool_mac[k - 1] : random_mac();
                pool_ip[k]  = (k % 4 == 2) ? pool_ip[k - 2] : random_ip();
            end
            repeat (MIXED_ITEMS) begin
                a = $urandom_range(0, KEY_POOL - 1);
                b = $urandom_range(0, KEY_POOL - 1);
                pick = $urandom_range(0, 99);
                if (pick < 60) clock_now += $urandom_range(0, 20);
                else if (pick < 90) clock_now += $urandom_range(20, 200);
                else if (pick < 98) clock_now += $urandom_range(200, 70000);
                else clock_now += $urandom;
                item = op_item(OP_ADD, pool_mac[a], pool_ip[a], clock_now, 1'($urandom));
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    item.operation = OP_ADD;
                end else if (pick < 55) begin
                    item.operation = OP_DELETE;
                end else if (pick < 65) begin
                    item.operation = OP_AUTHORIZE;
                end else if (pick < 75) begin
                    item.operation = OP_LOOKUP_IP;
                    item.station_mac = random_mac();
                    if ($urandom_range(0, 4) == 0) item.station_ip = random_ip();
                end else if (pick < 85) begin
                    item.operation = OP_LOOKUP_MAC;
                    item.station_ip = random_ip();
                    if ($urandom_range(0, 4) == 0) item.station_mac = random_mac();
                end else if (pick < 89) begin
                    item.operation = OP_CLEAR_AUTH;
                    item.station_mac = random_mac();
                    item.station_ip  = random_ip();
                end else if (pick < 93) begin
                    // MAC of one station with the IP of another.
                    item.operation = KEYED_OPS[$urandom_range(1, 2)];
                    item.station_ip = pool_ip[b];
                end else if (pick < 96) begin
                    item.operation = KEYED_OPS[$urandom_range(0, 4)];
                    zero_sel = $urandom_range(0, 2);
                    if (zero_sel != 1) item.station_mac = '0;
                    if (zero_sel != 0) item.station_ip = '0;
                end else if (pick < 98) begin
                    item.operation = ($urandom_range(0, 1) == 0) ? OP_RESERVED_LO : OP_RESERVED_HI;
                    item.station_mac = {16'($urandom), $urandom};
                    item.station_ip  = $urandom;
                end else begin
                    item.operation = KEYED_OPS[$urandom_range(0, 2)];
                    item.station_mac = random_mac();
                    item.station_ip  = random_ip();
                end
                send_op(item, reply);
            end
        end
    endtask

    task automatic test_full_table();
        t_out_item reply;
        int        adds, low_slot, high_slot;
        write_hold_off('0);
        clock_now = 32'h8000_0000;
        adds = 0;
        do begin
            clock_now++;
            send_op(op_item(OP_ADD, random_mac(), random_ip(), clock_now, 1'($urandom)), reply);
            adds++;
        end while (reply.status != STAT_FULL && adds < 2 * TABLE_SIZE);
        send_op(op_item(OP_ADD, random_mac(), random_ip(), clock_now, 1'b1), reply);
        low_slot  = $urandom_range(0, TABLE_SIZE / 2 - 1);
        high_slot = $urandom_range(TABLE_SIZE / 2, TABLE_SIZE - 1);
        // A refresh still works on a full table.
        send_op(op_item(OP_ADD, station_tbl[low_slot].mac, station_tbl[low_slot].ip,
                        clock_now, 1'b0), reply);
        send_op(op_item(OP_AUTHORIZE, station_tbl[TABLE_SIZE - 1].mac,
                        station_tbl[TABLE_SIZE - 1].ip, clock_now, 1'b0), reply);
        send_op(op_item(OP_LOOKUP_MAC, station_tbl[TABLE_SIZE - 1].mac, '0,
                        clock_now, 1'b0), reply);
        send_op(op_item(OP_LOOKUP_IP, '0, station_tbl[high_slot].ip, clock_now, 1'b0), reply);
        // Free two slots; new stations refill the lower one first.
        send_op(op_item(OP_DELETE, station_tbl[high_slot].mac, station_tbl[high_slot].ip,
                        clock_now, 1'b0), reply);
        send_op(op_item(OP_DELETE, station_tbl[low_slot].mac, station_tbl[low_slot].ip,
                        clock_now, 1'b0), reply);
        repeat (3) begin
            send_op(op_item(OP_ADD, random_mac(), random_ip(), clock_now, 1'($urandom)), reply);
        end
        for (int s = 0; s < TABLE_SIZE; s += $urandom_range(1, 6)) begin
            clock_now += $urandom_range(0, 3);
            send_op(op_item(OP_DELETE, station_tbl[s].mac, station_tbl[s].ip,
                            clock_now, 1'b0), reply);
        end
        send_op(op_item(OP_CLEAR_AUTH, '0, '0, clock_now, 1'b0), reply);
    endtask

    // Checks every result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid !== 1'b0 && i_out_stall == 1'b0) begin
            if (pending_replies.size() == 0) begin
                $error("result transaction with no operation outstanding: 0x%0h", o_out_data);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                compare_field("status", 64'(want.status), 64'(o_out_data.status));
                compare_field("slot_index", 64'(want.slot_index),
                              64'(o_out_data.slot_index));
                compare_field("found_mac", 64'(want.found_mac), 64'(o_out_data.found_mac));
                compare_field("found_ip", 64'(want.found_ip), 64'(o_out_data.found_ip));
                compare_field("found_auth", 64'(want.found_auth),
                              64'(o_out_data.found_auth));
                compare_field("found_wireless", 64'(want.found_wireless),
                              64'(o_out_data.found_wireless));
            end
        end
    end

    // Receiver back-pressure, with long stretches of no stall at all now and then.
    initial begin
        int stall_cycles, free_cycles;
        forever begin
            stall_cycles = idle_length();
            free_cycles = ($urandom_range(0, 29) == 0) ? $urandom_range(300, 2000)
                                                       : $urandom_range(1, 40);
            repeat (stall_cycles) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
            repeat (free_cycles) begin
                @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    initial begin
        #15_000_000;
        $display("** station_table_engine_top: FAILED **");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_ops();
        test_hold_off_limits();
        test_mixed_traffic();
        test_full_table();
        settle_queue();
        repeat (TABLE_SIZE + 64) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** station_table_engine_top: PASSED **");
        end else begin
            $display("** station_table_engine_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ste_pkg.sv
hdl/ste_engine.sv
hdl/station_table_engine_top.sv
sim/testbench.sv
